// ===== rtl/ncpr_pkg.sv =====
// shared types, constants and lookup tables for the note color pixel renderer
`timescale 1ns / 1ps
`default_nettype none
package ncpr_pkg;

   // number of keys in the position table
   localparam int KEY_COUNT = 80;
   // multiple of 12 added so the note class sum never goes negative
   localparam int CLASS_BIAS = 132;
   // fixed-point scale factor per unit of scaled brightness
   localparam int GAIN_MUL = 655;
   // gain after reset: brightness 100 gives 75, times 655
   localparam logic [15:0] GAIN_RESET = 16'd49125;
   localparam logic [23:0] GREY_COLOR = 24'hB3B3B3;
   localparam logic [23:0] BLACK_COLOR = 24'h000000;

   // configuration register indexes
   typedef enum logic [3:0] {
      CSR_BRIGHTNESS   = 4'd0,
      CSR_LEFT_MODE    = 4'd1,
      CSR_RIGHT_MODE   = 4'd2,
      CSR_LEFT_SEMI    = 4'd3,
      CSR_RIGHT_SEMI   = 4'd4,
      CSR_LEFT_ANCHOR  = 4'd5,
      CSR_RIGHT_ANCHOR = 4'd6,
      CSR_BASS_SHIFT   = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ZN_CTRL  = 2'd0,
      ZN_GRID  = 2'd1,
      ZN_THUMB = 2'd2,
      ZN_BASS  = 2'd3
   } zone_type;

   // how stage d picks the color
   typedef enum logic [1:0] {
      KIND_BLACK = 2'd0,
      KIND_GREY  = 2'd1,
      KIND_GRID  = 2'd2,
      KIND_SOFT  = 2'd3
   } kind_type;

   typedef struct packed {
      zone_type   zone;
      logic       hand;
      logic [1:0] row;
      logic [2:0] col;
   } key_info_type;

   // register view handed to the pipeline
   typedef struct packed {
      logic [15:0] gain;
      logic        left_mode;
      logic        right_mode;
      logic [6:0]  left_semi;
      logic [6:0]  right_semi;
      logic [6:0]  left_anchor;
      logic [6:0]  right_anchor;
      logic [6:0]  bass_shift;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [8:0] cls_biased;
      logic       last;
   } class_item_type;

   typedef struct packed {
      logic [23:0] hex;
      logic        last;
   } color_item_type;

   // position table packed as {zone, hand, row, col}
   localparam logic [7:0] KEY_ROM [KEY_COUNT] = '{
      8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
      8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
      8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5C, 8'h5D,
      8'h78, 8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D,
      8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55,
      8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75,
      8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D,
      8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D,
      8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
      8'h88, 8'h89, 8'h8A,
      8'hAB, 8'hA5, 8'hAD,
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65,
      8'h00, 8'h01,
      8'hC0, 8'hC1, 8'hC2,
      8'h80, 8'h81, 8'h82,
      8'hA3, 8'hA4, 8'hAC,
      8'hE0, 8'hE1, 8'hE2,
      8'h21, 8'h20
   };

   function automatic key_info_type key_lookup(input logic [6:0] idx);
      key_info_type info;
      info = '0;
      if (idx < 7'(KEY_COUNT)) begin
         info = key_info_type'(KEY_ROM[idx]);
      end
      return info;
   endfunction

   // two-octave layout: even rows take the white-ish set, odd rows the rest
   function automatic logic [3:0] row_class(input logic odd, input logic [2:0] col);
      logic [3:0] cls;
      case ({odd, col})
         4'b0_000, 4'b0_110: cls = 4'd0;
         4'b0_001, 4'b0_111: cls = 4'd2;
         4'b0_010: cls = 4'd4;
         4'b0_011: cls = 4'd7;
         4'b0_100: cls = 4'd9;
         4'b0_101: cls = 4'd11;
         4'b1_000, 4'b1_110: cls = 4'd1;
         4'b1_001, 4'b1_111: cls = 4'd3;
         4'b1_010: cls = 4'd5;
         4'b1_011: cls = 4'd6;
         4'b1_100: cls = 4'd8;
         4'b1_101: cls = 4'd10;
         default:  cls = 4'd0;
      endcase
      return cls;
   endfunction

   function automatic logic [23:0] chroma_color(input logic [3:0] cls);
      logic [23:0] hex;
      case (cls)
         4'd0:    hex = 24'hFF0000;
         4'd1:    hex = 24'hFF4500;
         4'd2:    hex = 24'hFFA500;
         4'd3:    hex = 24'hFFFF00;
         4'd4:    hex = 24'h80FF00;
         4'd5:    hex = 24'h00FF00;
         4'd6:    hex = 24'h00E05F;
         4'd7:    hex = 24'h00FFFF;
         4'd8:    hex = 24'h0000FF;
         4'd9:    hex = 24'h8000FF;
         4'd10:   hex = 24'h7A00FF;
         4'd11:   hex = 24'hFF00FF;
         default: hex = BLACK_COLOR;
      endcase
      return hex;
   endfunction

   // note colors washed toward white for thumb and bass keys
   function automatic logic [23:0] soft_color(input logic [3:0] cls);
      logic [23:0] hex;
      case (cls)
         4'd0:    hex = 24'hFF3F3F;
         4'd1:    hex = 24'hFF733F;
         4'd2:    hex = 24'hFFBB3F;
         4'd3:    hex = 24'hFFFF3F;
         4'd4:    hex = 24'h9FFF3F;
         4'd5:    hex = 24'h3FFF3F;
         4'd6:    hex = 24'h3FE787;
         4'd7:    hex = 24'h3FFFFF;
         4'd8:    hex = 24'h3F3FFF;
         4'd9:    hex = 24'h5C26FF;
         4'd10:   hex = 24'hB73FFF;
         4'd11:   hex = 24'hFF82FF;
         default: hex = BLACK_COLOR;
      endcase
      return hex;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ncpr_ifs.sv =====
// valid/ready channel interfaces for pixel requests, colors and register writes
`timescale 1ns / 1ps
`default_nettype none
interface ncpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_position;
   logic       last_pixel;
   modport source(output valid, output key_position, output last_pixel, input ready);
   modport sink(input valid, input key_position, input last_pixel, output ready);
endinterface

interface ncpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_end;
   modport source(output valid, output red, output green, output blue,
                  output frame_end, input ready);
   modport sink(input valid, input red, input green, input blue,
                input frame_end, output ready);
endinterface

interface ncpr_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [6:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ncpr_decode.sv =====
// stages a and b: position table lookup, then the biased note class sum
`timescale 1ns / 1ps
`default_nettype none
module ncpr_decode (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ncpr_pkg::cfg_type        cfg,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [7:0]               key_position,
   input  wire logic                     last_pixel,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output ncpr_pkg::class_item_type      out_item
);

   logic                   a_valid_ff;
   ncpr_pkg::key_info_type a_info_ff, a_info_in;
   logic                   a_range_ff, a_range_in;
   logic                   a_last_ff;
   logic                   a_ready;

   logic                     b_valid_ff;
   ncpr_pkg::class_item_type b_item_ff, b_item_in;

   logic              mode;
   logic [6:0]        semi;
   logic [6:0]        anchor;
   logic signed [9:0] base;
   logic signed [9:0] shift;
   logic signed [9:0] sum;

   // stage a: table lookup
   assign a_range_in = (key_position < 8'(ncpr_pkg::KEY_COUNT));
   assign a_info_in  = ncpr_pkg::key_lookup(key_position[6:0]);
   assign a_ready    = !b_valid_ff || out_ready;
   assign in_ready   = !a_valid_ff || a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (in_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         a_info_ff  <= a_info_in;
         a_range_ff <= a_range_in;
         a_last_ff  <= last_pixel;
      end
   end

   // stage b: per-hand settings select
   always_comb begin
      mode   = a_info_ff.hand ? cfg.right_mode : cfg.left_mode;
      semi   = a_info_ff.hand ? cfg.right_semi : cfg.left_semi;
      anchor = a_info_ff.hand ? cfg.right_anchor : cfg.left_anchor;
   end

   // stage b: note class before reduction, biased to stay positive
   always_comb begin
      base  = '0;
      shift = '0;
      case (a_info_ff.zone)
         ncpr_pkg::ZN_GRID: begin
            shift = {{3{semi[6]}}, semi};
            if (!mode) begin
               base = {6'b0, ncpr_pkg::row_class(a_info_ff.row[0], a_info_ff.col)};
            end else begin
               base = {{3{anchor[6]}}, anchor} + {6'b0, a_info_ff.col, 1'b0}
                      + {8'b0, a_info_ff.row};
            end
         end
         ncpr_pkg::ZN_THUMB: begin
            shift = {{3{cfg.bass_shift[6]}}, cfg.bass_shift};
            base  = {6'b0, a_info_ff.col, 1'b0} + {8'b0, a_info_ff.row};
         end
         ncpr_pkg::ZN_BASS: begin
            shift = {{3{cfg.bass_shift[6]}}, cfg.bass_shift};
            base  = a_info_ff.hand ? {7'b0, a_info_ff.col} : 10'sd9 + {7'b0, a_info_ff.col};
         end
         default: begin
            base  = '0;
            shift = '0;
         end
      endcase
      sum = base + shift + 10'(ncpr_pkg::CLASS_BIAS);
   end

   // stage b: color kind
   always_comb begin
      b_item_in.cls_biased = sum[8:0];
      b_item_in.last       = a_last_ff;
      if (!a_range_ff) begin
         b_item_in.kind = ncpr_pkg::KIND_BLACK;
      end else begin
         case (a_info_ff.zone)
            ncpr_pkg::ZN_CTRL: b_item_in.kind = ncpr_pkg::KIND_GREY;
            ncpr_pkg::ZN_GRID: b_item_in.kind = ncpr_pkg::KIND_GRID;
            default:           b_item_in.kind = ncpr_pkg::KIND_SOFT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && a_ready) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule
`default_nettype wire

// ===== rtl/ncpr_color.sv =====
// stages c and d: floor-mod 12 of the note class, then the color table
`timescale 1ns / 1ps
`default_nettype none
module ncpr_color (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire ncpr_pkg::class_item_type in_item,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output ncpr_pkg::color_item_type      out_item
);

   logic                c_valid_ff;
   ncpr_pkg::kind_type  c_kind_ff;
   logic [3:0]          c_cls_ff, c_cls_in;
   logic                c_last_ff;
   logic                c_ready;

   logic                     d_valid_ff;
   ncpr_pkg::color_item_type d_item_ff, d_item_in;

   logic [16:0] recip;
   logic [5:0]  quot;
   logic [8:0]  rem;

   // stage c: quotient by reciprocal 171/2048, exact for every 9-bit sum
   always_comb begin
      recip    = {8'b0, in_item.cls_biased} * 17'd171;
      quot     = recip[16:11];
      rem      = in_item.cls_biased - ({quot, 3'b0} + {1'b0, quot, 2'b0});
      c_cls_in = rem[3:0];
   end

   assign c_ready  = !d_valid_ff || out_ready;
   assign in_ready = !c_valid_ff || c_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (in_ready) begin
         c_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         c_kind_ff <= in_item.kind;
         c_cls_ff  <= c_cls_in;
         c_last_ff <= in_item.last;
      end
   end

   // stage d: color select
   always_comb begin
      d_item_in.last = c_last_ff;
      case (c_kind_ff)
         ncpr_pkg::KIND_GRID: d_item_in.hex = ncpr_pkg::chroma_color(c_cls_ff);
         ncpr_pkg::KIND_SOFT: d_item_in.hex = ncpr_pkg::soft_color(c_cls_ff);
         ncpr_pkg::KIND_GREY: d_item_in.hex = ncpr_pkg::GREY_COLOR;
         default:             d_item_in.hex = ncpr_pkg::BLACK_COLOR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (c_ready) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_valid_ff && c_ready) begin
         d_item_ff <= d_item_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_item  = d_item_ff;

endmodule
`default_nettype wire

// ===== rtl/ncpr_scale.sv =====
// stage e: brightness scaling of each channel into the output register
`timescale 1ns / 1ps
`default_nettype none
module ncpr_scale (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [15:0]              gain,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire ncpr_pkg::color_item_type in_item,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [7:0]                    red,
   output logic [7:0]                    green,
   output logic [7:0]                    blue,
   output logic                          frame_end
);

   logic        e_valid_ff;
   logic [7:0]  red_ff, green_ff, blue_ff;
   logic        last_ff;
   logic [23:0] red_in, green_in, blue_in;

   // channel times gain, keep the top byte
   always_comb begin
      red_in   = {16'b0, in_item.hex[23:16]} * {8'b0, gain};
      green_in = {16'b0, in_item.hex[15:8]} * {8'b0, gain};
      blue_in  = {16'b0, in_item.hex[7:0]} * {8'b0, gain};
   end

   assign in_ready = !e_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (in_ready) begin
         e_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         red_ff   <= red_in[23:16];
         green_ff <= green_in[23:16];
         blue_ff  <= blue_in[23:16];
         last_ff  <= in_item.last;
      end
   end

   assign out_valid = e_valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;
   assign frame_end = last_ff;

endmodule
`default_nettype wire

// ===== rtl/note_color_pixel_renderer_unit.sv =====
// Note color pixel renderer: maps a key position to a scaled RGB pixel color.
// Five register stages (table lookup, class sum, mod 12, color select,
// brightness multiply) take one item per clock when the output is not
// stalled; each stage holds its item under backpressure, so a stalled output
// lets the upstream stages keep filling. Register writes are taken every
// cycle; brightness is folded into a 16-bit gain at write time, and writes
// to indexes beyond the eight registers are dropped.
`timescale 1ns / 1ps
`default_nettype none
module note_color_pixel_renderer_unit (
   input  wire logic clock,
   input  wire logic reset,
   ncpr_req_if.sink   req_ch,
   ncpr_rsp_if.source rsp_ch,
   ncpr_csr_if.sink   csr_ch
);

   ncpr_pkg::cfg_type        cfg_ff;
   logic [8:0]               bright3;
   logic [6:0]               scaled;
   logic [15:0]              gain_in;

   logic                     b_valid, b_ready;
   ncpr_pkg::class_item_type b_item;
   logic                     d_valid, d_ready;
   ncpr_pkg::color_item_type d_item;

   // brightness * 75 / 100 is exactly 3 * brightness / 4
   always_comb begin
      bright3 = {2'b0, csr_ch.data} + {1'b0, csr_ch.data, 1'b0};
      scaled  = bright3[8:2];
      gain_in = {9'b0, scaled} * 16'(ncpr_pkg::GAIN_MUL);
   end

   assign csr_ch.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain         <= ncpr_pkg::GAIN_RESET;
         cfg_ff.left_mode    <= 1'b0;
         cfg_ff.right_mode   <= 1'b0;
         cfg_ff.left_semi    <= '0;
         cfg_ff.right_semi   <= '0;
         cfg_ff.left_anchor  <= '0;
         cfg_ff.right_anchor <= '0;
         cfg_ff.bass_shift   <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            ncpr_pkg::CSR_BRIGHTNESS:   cfg_ff.gain         <= gain_in;
            ncpr_pkg::CSR_LEFT_MODE:    cfg_ff.left_mode    <= csr_ch.data[0];
            ncpr_pkg::CSR_RIGHT_MODE:   cfg_ff.right_mode   <= csr_ch.data[0];
            ncpr_pkg::CSR_LEFT_SEMI:    cfg_ff.left_semi    <= csr_ch.data;
            ncpr_pkg::CSR_RIGHT_SEMI:   cfg_ff.right_semi   <= csr_ch.data;
            ncpr_pkg::CSR_LEFT_ANCHOR:  cfg_ff.left_anchor  <= csr_ch.data;
            ncpr_pkg::CSR_RIGHT_ANCHOR: cfg_ff.right_anchor <= csr_ch.data;
            ncpr_pkg::CSR_BASS_SHIFT:   cfg_ff.bass_shift   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // pipeline
   ncpr_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .key_position (req_ch.key_position),
      .last_pixel   (req_ch.last_pixel),
      .out_valid    (b_valid),
      .out_ready    (b_ready),
      .out_item     (b_item)
   );

   ncpr_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_item   (b_item),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_item  (d_item)
   );

   ncpr_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .gain      (cfg_ff.gain),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_item   (d_item),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .red       (rsp_ch.red),
      .green     (rsp_ch.green),
      .blue      (rsp_ch.blue),
      .frame_end (rsp_ch.frame_end)
   );

endmodule
`default_nettype wire

// ===== rtl/ncpr_checker.sv =====
// port-level checks for the note color pixel renderer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ncpr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_red,
   input wire logic [7:0] rsp_green,
   input wire logic [7:0] rsp_blue,
   input wire logic       rsp_frame_end,
   input wire logic       csr_ready
);

   // a held color must not change while the sink stalls
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue) && $stable(rsp_frame_end))
      else $error("stalled color item changed or dropped");

   // the pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("color item shown after reset");

   // an open output lets every stage move, so input is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while output is open");

   // register writes are never held off
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register port not ready");

   // nothing comes out right after reset falls while no request is presented, as an item must pass the five stages
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) ##0 !req_valid |=> !rsp_valid)
      else $error("color item without a request");

endmodule

bind note_color_pixel_renderer_unit ncpr_checker u_ncpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_red       (rsp_ch.red),
   .rsp_green     (rsp_ch.green),
   .rsp_blue      (rsp_ch.blue),
   .rsp_frame_end (rsp_ch.frame_end),
   .csr_ready     (csr_ch.ready)
);
`default_nettype wire
